/* hw/rtl/aps_pkg.sv */
// Shared constants, types and the control word of the all-pairs shortest path block.
// Used by aps_cell and all_pairs_shortest_path_top; depends on nothing.
package aps_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int VW = $clog2(MAX_VERTICES);  // vertex index width
  localparam int CW = VW + 1;                // count width, holds MAX_VERTICES
  localparam int DW = 27;                    // distance width
  localparam int WW = 20;                    // edge weight width
  localparam int CFG_W = 7;                  // vertex_count register width
  localparam logic [DW-1:0] NO_EDGE = DW'(99999);

  typedef enum logic [1:0] {
    ACT_CLEAR = 2'd0,
    ACT_EDGE  = 2'd1,
    ACT_RUN   = 2'd2,
    ACT_READ  = 2'd3
  } action_e;

  // Control word broadcast from the sequencer to every column cell
  typedef struct packed {
    logic [VW-1:0] raddr;       // row read in all cells
    logic          clr;         // clear write of row ext_addr in all cells
    logic          wr_edge;     // weight write into one column
    logic [VW-1:0] edge_col;    // column of the weight write
    logic [VW-1:0] ext_addr;    // row of a clear or weight write
    logic [DW-1:0] edge_wdata;  // weight, zero extended
    logic          load_row;    // capture row k from the read data
    logic          relax_we;    // relax row relax_addr
    logic [VW-1:0] relax_addr;
    logic [CW-1:0] ncols;       // active vertex count, columns at or above it hold
  } cell_ctl_t;

endpackage

/* hw/rtl/all_pairs_shortest_path_top.sv */
// All-pairs shortest path (Floyd-Warshall) top level with its sequencer.
// Depends on aps_pkg and aps_cell.
//
// The matrix is held column by column in a row of MAX_VERTICES cells, each with
// a small RAM of its own; all cells work on the same row in the same cycle. Clear
// writes one row a cycle. Run, for each pivot k, loads row k, sweeps the rows
// and drains the read-relax-write pipeline, with n = vertex_count (capped at
// MAX_VERTICES). One word is worked at a time; the result sits in an output
// register, and the next word is taken once it has left. The matrix is
// undefined until the first clear.
module all_pairs_shortest_path_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [1:0]                action_i,
  input  logic [aps_pkg::VW-1:0]    src_vertex_i,
  input  logic [aps_pkg::VW-1:0]    dst_vertex_i,
  input  logic [aps_pkg::WW-1:0]    edge_weight_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [aps_pkg::DW-1:0]    distance_o,
  output logic                      index_error_o,
  output logic                      done_res_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [aps_pkg::CFG_W-1:0] cfg_data_i
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_CLEAR, ST_LOAD, ST_LWAIT, ST_SWEEP, ST_DRAIN, ST_READ
  } state_e;

  state_e                    state_q;
  logic [aps_pkg::CFG_W-1:0] vcount_q;
  logic [aps_pkg::CW-1:0]    n;
  logic [aps_pkg::CW-1:0]    k_q, i_q;
  logic [aps_pkg::VW-1:0]    rd_col_q;
  logic                      v1_q, v2_q;
  logic [aps_pkg::VW-1:0]    a1_q, a2_q;
  logic [aps_pkg::DW-1:0]    piv_q;
  logic                      out_valid_q, err_q;
  logic [aps_pkg::DW-1:0]    dist_q;
  logic                      accept, in_range;
  aps_pkg::action_e          act;
  aps_pkg::cell_ctl_t        ctl;
  logic [aps_pkg::DW-1:0]    rdata_w [aps_pkg::MAX_VERTICES];

  assign act = aps_pkg::action_e'(action_i);
  assign n = (vcount_q > aps_pkg::CFG_W'(aps_pkg::MAX_VERTICES)) ?
             aps_pkg::CW'(aps_pkg::MAX_VERTICES) : aps_pkg::CW'(vcount_q);
  assign in_range = ({1'b0, src_vertex_i} < n) && ({1'b0, dst_vertex_i} < n);
  assign in_stall_o = !((state_q == ST_IDLE) && !out_valid_q);
  assign accept = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  // drive the cell control word
  always_comb begin
    ctl            = '0;
    ctl.ext_addr   = (state_q == ST_CLEAR) ? i_q[aps_pkg::VW-1:0] : src_vertex_i;
    ctl.edge_col   = dst_vertex_i;
    ctl.edge_wdata = aps_pkg::DW'(edge_weight_i);
    ctl.clr        = (state_q == ST_CLEAR);
    ctl.wr_edge    = accept && (act == aps_pkg::ACT_EDGE) && in_range;
    ctl.load_row   = (state_q == ST_LWAIT);
    ctl.relax_we   = v2_q;
    ctl.relax_addr = a2_q;
    ctl.ncols      = n;
    unique case (state_q)
      ST_LOAD:  ctl.raddr = k_q[aps_pkg::VW-1:0];
      ST_SWEEP: ctl.raddr = i_q[aps_pkg::VW-1:0];
      default:  ctl.raddr = src_vertex_i;
    endcase
  end

  // row of column cells
  for (genvar c = 0; c < aps_pkg::MAX_VERTICES; c++) begin : g_cell
    aps_cell u_cell (
      .clk_i  (clk_i),
      .col_i  (aps_pkg::VW'(c)),
      .ctl_i  (ctl),
      .piv_i  (piv_q),
      .rdata_o(rdata_w[c])
    );
  end

  // pivot column value and relax pipeline address
  always_ff @(posedge clk_i) begin
    piv_q <= rdata_w[k_q[aps_pkg::VW-1:0]];
    a1_q  <= i_q[aps_pkg::VW-1:0];
    a2_q  <= a1_q;
  end

  // sequencer, configuration and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      vcount_q    <= aps_pkg::CFG_W'(aps_pkg::MAX_VERTICES);
      k_q         <= '0;
      i_q         <= '0;
      rd_col_q    <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
      err_q       <= 1'b0;
      dist_q      <= '0;
    end else begin
      if (cfg_valid_i) begin
        vcount_q <= cfg_data_i;
      end
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      v1_q <= (state_q == ST_SWEEP);
      v2_q <= v1_q;
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            err_q  <= 1'b0;
            dist_q <= '0;
            i_q    <= '0;
            k_q    <= '0;
            unique case (act)
              aps_pkg::ACT_CLEAR: state_q <= ST_CLEAR;
              aps_pkg::ACT_EDGE: begin
                err_q       <= !in_range;
                out_valid_q <= 1'b1;
              end
              aps_pkg::ACT_RUN: begin
                if (n == '0) begin
                  out_valid_q <= 1'b1;
                end else begin
                  state_q <= ST_LOAD;
                end
              end
              aps_pkg::ACT_READ: begin
                if (in_range) begin
                  rd_col_q <= dst_vertex_i;
                  state_q  <= ST_READ;
                end else begin
                  err_q       <= 1'b1;
                  out_valid_q <= 1'b1;
                end
              end
              default: state_q <= ST_IDLE;
            endcase
          end
        end
        ST_CLEAR: begin
          if (i_q == aps_pkg::CW'(aps_pkg::MAX_VERTICES - 1)) begin
            state_q     <= ST_IDLE;
            out_valid_q <= 1'b1;
          end
          i_q <= i_q + 1'b1;
        end
        ST_LOAD:  state_q <= ST_LWAIT;
        ST_LWAIT: begin
          i_q     <= '0;
          state_q <= ST_SWEEP;
        end
        ST_SWEEP: begin
          if (i_q == n - 1'b1) begin
            state_q <= ST_DRAIN;
          end
          i_q <= i_q + 1'b1;
        end
        ST_DRAIN: begin
          if (!v1_q && !v2_q) begin
            if (k_q == n - 1'b1) begin
              state_q     <= ST_IDLE;
              out_valid_q <= 1'b1;
            end else begin
              state_q <= ST_LOAD;
            end
            k_q <= k_q + 1'b1;
          end
        end
        ST_READ: begin
          dist_q      <= rdata_w[rd_col_q];
          out_valid_q <= 1'b1;
          state_q     <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign distance_o    = dist_q;
  assign index_error_o = err_q;
  assign done_res_o    = 1'b1;

endmodule

/* hw/rtl/aps_ram.sv */
// Generic single write, single read RAM with registered read data.
// No dependencies.
module aps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/aps_cell.sv */
// One column cell: holds column col_i of the distance matrix and relaxes it.
// Depends on aps_pkg and aps_ram.
module aps_cell (
  input  logic                   clk_i,
  input  logic [aps_pkg::VW-1:0] col_i,
  input  aps_pkg::cell_ctl_t     ctl_i,
  input  logic [aps_pkg::DW-1:0] piv_i,   // d[i][k] from the pivot column
  output logic [aps_pkg::DW-1:0] rdata_o
);

  logic [aps_pkg::DW-1:0] rowk_q;   // d[k][col]
  logic [aps_pkg::DW-1:0] cur_q;    // d[i][col], registered from the RAM output
  logic [aps_pkg::DW:0]   sum;
  logic                   upd;
  logic                   edge_hit;
  logic                   col_active;
  logic                   we;
  logic [aps_pkg::VW-1:0] waddr;
  logic [aps_pkg::DW-1:0] wdata;

  // capture the pivot row and the current entry
  always_ff @(posedge clk_i) begin
    cur_q <= rdata_o;
    if (ctl_i.load_row) begin
      rowk_q <= rdata_o;
    end
  end

  // path through k, one bit wider
  assign sum = {1'b0, piv_i} + {1'b0, rowk_q};
  assign upd = sum < {1'b0, cur_q};
  assign edge_hit = ctl_i.wr_edge && (ctl_i.edge_col == col_i);
  // only columns below the vertex count take part in a run
  assign col_active = ({1'b0, col_i} < ctl_i.ncols);

  // select the write source
  always_comb begin
    we    = 1'b0;
    waddr = ctl_i.relax_addr;
    wdata = sum[aps_pkg::DW-1:0];
    if (ctl_i.clr) begin
      we    = 1'b1;
      waddr = ctl_i.ext_addr;
      wdata = (ctl_i.ext_addr == col_i) ? '0 : aps_pkg::NO_EDGE;
    end else if (edge_hit) begin
      we    = 1'b1;
      waddr = ctl_i.ext_addr;
      wdata = ctl_i.edge_wdata;
    end else if (ctl_i.relax_we && upd && col_active) begin
      we    = 1'b1;
    end
  end

  aps_ram #(
    .WIDTH(aps_pkg::DW),
    .DEPTH(aps_pkg::MAX_VERTICES)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(ctl_i.raddr),
    .rdata_o(rdata_o)
  );

endmodule
